// ----- hw/rtl/spr_pkg.sv -----
// ============================================================================
// spr_pkg : shared types and constants of the spatial predictor
// Register map, predictor mode codes, and the queue geometry shared by
// the front end, the queue and the back end.
// ============================================================================
package spr_pkg;

    // default row store depth, pixels per row at most
    localparam int MAX_WIDTH_DEF = 4096;

    // image_width register width
    localparam int WIDTH_W = 13;

    // front to back queue geometry (depth is a power of two)
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    // register indices (paddr[3:2])
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_DIR   = 2'd1;
    localparam logic [1:0] REG_WIDTH = 2'd2;

    // predictor modes
    localparam logic [3:0] MODE_ZERO      = 4'd0;
    localparam logic [3:0] MODE_L         = 4'd1;
    localparam logic [3:0] MODE_T         = 4'd2;
    localparam logic [3:0] MODE_TR        = 4'd3;
    localparam logic [3:0] MODE_TL        = 4'd4;
    localparam logic [3:0] MODE_AVG_LT    = 4'd5;
    localparam logic [3:0] MODE_AVG_LTTR  = 4'd6;
    localparam logic [3:0] MODE_AVG_LTL   = 4'd7;
    localparam logic [3:0] MODE_AVG_TTR   = 4'd8;
    localparam logic [3:0] MODE_AVG_TTL   = 4'd9;
    localparam logic [3:0] MODE_AVG_ALL   = 4'd10;
    localparam logic [3:0] MODE_SELECT    = 4'd11;
    localparam logic [3:0] MODE_CLAMP     = 4'd12;

    // reset values of the registers
    localparam logic [3:0]         MODE_RESET  = MODE_SELECT;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd4096;

    localparam logic [7:0] BYTE_MAX = 8'hFF;

    // neighbour availability worked out by the front end
    typedef struct packed {
        logic has_left;  // column > 0
        logic has_top;   // past first row
        logic use_tr;    // top-right lies inside the row
    } t_fe_flags;

endpackage

// ----- hw/rtl/spatial_predictor_residual_unit.sv -----
// ============================================================================
// spatial_predictor_residual_unit : lossless spatial predictor, RGBA8
// Subtract-green plus one of 13 neighbour predictors, encode or decode.
// ============================================================================
// Takes one RGBA pixel word a cycle and returns one word a cycle, sustained
// while the output is not stalled, in either direction; a result word passes
// through the F1 register and row store read, then the queue, then the
// output register. The rate is bounded by the
// compute stage, whose left neighbour of each pixel is the previous pixel's
// result, and by the row store, which takes one top / top-right read pair and
// one write per pixel. The row store needs no clearing pass: its read data is
// only used at entries already written in the current frame. Mark the first
// pixel of a frame with tuser; row and column then restart, and rows wrap at
// image_width (0 acts as 1, values above MAX_WIDTH act as MAX_WIDTH).
// Change registers only while the block is idle.
// ============================================================================
module spatial_predictor_residual_unit #(
    parameter int MAX_WIDTH = spr_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic        i_s_tuser,   // [0] frame_start
    input  logic [31:0] i_s_tdata,   // [7:0] in_red, [15:8] in_green,
                                     // [23:16] in_blue, [31:24] in_alpha
    // result out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] out_red, [15:8] out_green,
                                     // [23:16] out_blue, [31:24] out_alpha
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int FW = $bits(spr_pkg::t_fe_flags);
    // queue word: {tr read, top read, column, flags, pixel}
    localparam int QW = 32 + 32 + AW + FW + 32;

    // ---- registers -------------------------------------------------------
    logic [3:0]                  r_mode;
    logic                        r_decode;
    logic [spr_pkg::WIDTH_W-1:0] r_width;
    logic                        cfg_wr;
    logic [1:0]                  reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= spr_pkg::MODE_RESET;
            r_decode <= 1'b0;
            r_width  <= spr_pkg::WIDTH_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                spr_pkg::REG_MODE:  r_mode   <= pwdata[3:0];
                spr_pkg::REG_DIR:   r_decode <= pwdata[0];
                spr_pkg::REG_WIDTH: r_width  <= pwdata[spr_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            spr_pkg::REG_MODE:  prdata = {28'b0, r_mode};
            spr_pkg::REG_DIR:   prdata = {31'b0, r_decode};
            spr_pkg::REG_WIDTH: prdata = {{(32 - spr_pkg::WIDTH_W){1'b0}}, r_width};
            default:            prdata = '0;
        endcase
    end

    // ---- interconnect ----------------------------------------------------
    logic                       rd_en;
    logic [AW-1:0]              rd_addr0;
    logic [AW-1:0]              rd_addr1;
    logic [31:0]                rd_data0;
    logic [31:0]                rd_data1;
    logic                       f1_valid;
    logic [31:0]                f1_pixel;
    spr_pkg::t_fe_flags         f1_flags;
    logic [AW-1:0]              f1_addr;
    logic [spr_pkg::Q_CW-1:0]   q_count;
    logic                       q_valid;
    logic [QW-1:0]              q_push_data;
    logic [QW-1:0]              q_head;
    logic                       q_pop;
    logic                       st_we;
    logic [AW-1:0]              st_waddr;
    logic [31:0]                st_wdata;
    logic [31:0]                hd_pixel;
    spr_pkg::t_fe_flags         hd_flags;
    logic [AW-1:0]              hd_addr;
    logic [31:0]                hd_top;
    logic [31:0]                hd_tr;

    // front end: position tracking, row store read issue
    spr_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tuser     (i_s_tuser),
        .i_s_tdata     (i_s_tdata),
        .i_image_width (r_width),
        .i_q_count     (q_count),
        .o_rd_en       (rd_en),
        .o_rd_addr0    (rd_addr0),
        .o_rd_addr1    (rd_addr1),
        .o_f1_valid    (f1_valid),
        .o_f1_pixel    (f1_pixel),
        .o_f1_flags    (f1_flags),
        .o_f1_addr     (f1_addr)
    );

    spr_row_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (st_we),
        .i_waddr  (st_waddr),
        .i_wdata  (st_wdata),
        .i_re     (rd_en),
        .i_raddr0 (rd_addr0),
        .i_raddr1 (rd_addr1),
        .o_rdata0 (rd_data0),
        .o_rdata1 (rd_data1)
    );

    // read data lands alongside F1; both go into the queue together
    assign q_push_data = {rd_data1, rd_data0, f1_addr, f1_flags, f1_pixel};

    spr_queue #(
        .DW (QW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (f1_valid),
        .i_push_data  (q_push_data),
        .i_pop        (q_pop),
        .o_head_valid (q_valid),
        .o_head_data  (q_head),
        .o_count      (q_count)
    );

    assign hd_pixel = q_head[31:0];
    assign hd_flags = q_head[32 +: FW];
    assign hd_addr  = q_head[32 + FW +: AW];
    assign hd_top   = q_head[32 + FW + AW +: 32];
    assign hd_tr    = q_head[64 + FW + AW +: 32];

    // back end: predict, residual / reconstruct, write back, present
    spr_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_decode     (r_decode),
        .i_head_valid (q_valid),
        .i_pixel      (hd_pixel),
        .i_flags      (hd_flags),
        .i_addr       (hd_addr),
        .i_top_raw    (hd_top),
        .i_tr_raw     (hd_tr),
        .o_pop        (q_pop),
        .o_we         (st_we),
        .o_waddr      (st_waddr),
        .o_wdata      (st_wdata),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata)
    );

endmodule

// ----- hw/rtl/spr_row_store.sv -----
// ============================================================================
// spr_row_store : previous-line pixel memory
// One write port, two registered read ports (top and top-right).
// ============================================================================
module spr_row_store #(
    parameter int MAX_WIDTH = spr_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr0,
    input  logic [AW-1:0] i_raddr1,
    output logic [31:0]   o_rdata0,
    output logic [31:0]   o_rdata1
);

    logic [31:0] r_mem [MAX_WIDTH];
    logic [31:0] r_rdata0;
    logic [31:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// ----- hw/rtl/spr_front.sv -----
// ============================================================================
// spr_front : pixel intake and position tracking
// Tracks column and row, works out neighbour availability, issues the row
// store reads and holds the word in register F1 while the read data lands.
// ============================================================================
module spr_front #(
    parameter int MAX_WIDTH = spr_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic                          i_s_tuser,
    input  logic [31:0]                   i_s_tdata,
    input  logic [spr_pkg::WIDTH_W-1:0]   i_image_width,
    input  logic [spr_pkg::Q_CW-1:0]      i_q_count,
    output logic                          o_rd_en,
    output logic [AW-1:0]                 o_rd_addr0,
    output logic [AW-1:0]                 o_rd_addr1,
    output logic                          o_f1_valid,
    output logic [31:0]                   o_f1_pixel,
    output spr_pkg::t_fe_flags            o_f1_flags,
    output logic [AW-1:0]                 o_f1_addr
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (CW > spr_pkg::WIDTH_W) ? CW : spr_pkg::WIDTH_W;

    logic [AW-1:0]            r_col;
    logic                     r_pfr;
    logic                     r_f1_valid;
    logic [31:0]              r_f1_pixel;
    spr_pkg::t_fe_flags       r_f1_flags;
    logic [AW-1:0]            r_f1_addr;

    logic [AW-1:0]            n_col;
    logic                     n_pfr;
    logic [spr_pkg::Q_CW:0]   inflight;
    logic                     accept;
    logic [AW-1:0]            cur_x;
    logic                     cur_pfr;
    logic [EW-1:0]            w_ext;
    logic [EW-1:0]            w_eff;
    logic [EW-1:0]            x_next;
    logic                     row_last;
    spr_pkg::t_fe_flags       flags;

    // room check: F1 always drains into the queue on the next cycle
    assign inflight   = {1'b0, i_q_count} + {{spr_pkg::Q_CW{1'b0}}, r_f1_valid};
    assign o_s_tready = inflight < (spr_pkg::Q_CW + 1)'(spr_pkg::Q_DEPTH);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        cur_x   = i_s_tuser ? '0 : r_col;
        cur_pfr = i_s_tuser ? 1'b0 : r_pfr;
        w_ext   = EW'(i_image_width);
        if (w_ext == '0) begin
            w_eff = EW'(1);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        x_next   = EW'(cur_x) + EW'(1);
        row_last = x_next >= w_eff;

        flags.has_left = cur_x != '0;
        flags.has_top  = cur_pfr;
        flags.use_tr   = cur_pfr && !row_last;

        n_col = row_last ? '0 : x_next[AW-1:0];
        n_pfr = row_last ? 1'b1 : cur_pfr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_pfr      <= 1'b0;
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_pfr <= n_pfr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_pixel <= i_s_tdata;
            r_f1_flags <= flags;
            r_f1_addr  <= cur_x;
        end
    end

    assign o_rd_en    = accept;
    assign o_rd_addr0 = cur_x;
    assign o_rd_addr1 = x_next[AW-1:0];
    assign o_f1_valid = r_f1_valid;
    assign o_f1_pixel = r_f1_pixel;
    assign o_f1_flags = r_f1_flags;
    assign o_f1_addr  = r_f1_addr;

`ifndef SYNTHESIS
    // F1 must always find room in the queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f1_valid |-> (i_q_count < spr_pkg::Q_CW'(spr_pkg::Q_DEPTH)))
        else $error("front: queue full while F1 holds a word");

    // a row end sends the next pixel to column 0 of a later row
    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && row_last) |=> (r_col == '0 && r_pfr))
        else $error("front: row end not taken");
`endif

endmodule

// ----- hw/rtl/spr_queue.sv -----
// ============================================================================
// spr_queue : short FIFO between front and back end
// ============================================================================
module spr_queue #(
    parameter int DW = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [DW-1:0]             i_push_data,
    input  logic                      i_pop,
    output logic                      o_head_valid,
    output logic [DW-1:0]             o_head_data,
    output logic [spr_pkg::Q_CW-1:0]  o_count
);

    logic [DW-1:0]             r_entry [spr_pkg::Q_DEPTH];
    logic [spr_pkg::Q_AW-1:0]  r_wr_ptr;
    logic [spr_pkg::Q_AW-1:0]  r_rd_ptr;
    logic [spr_pkg::Q_CW-1:0]  r_count;
    logic                      do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + spr_pkg::Q_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + spr_pkg::Q_AW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + spr_pkg::Q_CW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - spr_pkg::Q_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head_valid = r_count != '0;
    assign o_head_data  = r_entry[r_rd_ptr];
    assign o_count      = r_count;

endmodule

// ----- hw/rtl/spr_back.sv -----
// ============================================================================
// spr_back : prediction, residual / reconstruction and output register
// One pixel a cycle while the output is not stalled; recent row store writes
// are forwarded over the read data captured by the front end.
// ============================================================================
module spr_back #(
    parameter int MAX_WIDTH = spr_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [3:0]          i_mode,
    input  logic                i_decode,
    input  logic                i_head_valid,
    input  logic [31:0]         i_pixel,
    input  spr_pkg::t_fe_flags  i_flags,
    input  logic [AW-1:0]       i_addr,
    input  logic [31:0]         i_top_raw,
    input  logic [31:0]         i_tr_raw,
    output logic                o_pop,
    output logic                o_we,
    output logic [AW-1:0]       o_waddr,
    output logic [31:0]         o_wdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [31:0]         o_m_tdata
);

    localparam int HN = spr_pkg::Q_DEPTH;

    function automatic logic [7:0] f_predict(
        input logic [3:0] mode,
        input logic [7:0] l,
        input logic [7:0] t,
        input logic [7:0] tr,
        input logic [7:0] tl
    );
        logic [8:0]         s_lt;
        logic [8:0]         s_ltl;
        logic [8:0]         s_ttr;
        logic [8:0]         s_ttl;
        logic [9:0]         s3;
        logic [9:0]         s4;
        logic [20:0]        m3;
        logic signed [10:0] g;
        logic signed [10:0] d_a;
        logic signed [10:0] d_b;
        logic signed [10:0] d_c;
        logic [10:0]        da;
        logic [10:0]        db;
        logic [10:0]        dc;
        logic [7:0]         p;
        s_lt  = {1'b0, l} + {1'b0, t} + 9'd1;
        s_ltl = {1'b0, l} + {1'b0, tl} + 9'd1;
        s_ttr = {1'b0, t} + {1'b0, tr} + 9'd1;
        s_ttl = {1'b0, t} + {1'b0, tl} + 9'd1;
        s3    = {2'b0, l} + {2'b0, t} + {2'b0, tr} + 10'd1;
        s4    = {2'b0, l} + {2'b0, t} + {2'b0, tr} + {2'b0, tl} + 10'd2;
        // divide by 3: s3 * 683 / 2048 is exact for s3 <= 766
        m3    = {11'b0, s3} * 21'd683;
        g     = $signed({3'b0, l}) + $signed({3'b0, t}) - $signed({3'b0, tl});
        // distances of the gradient to L, T and TL
        d_a   = $signed({3'b0, t}) - $signed({3'b0, tl});
        d_b   = $signed({3'b0, l}) - $signed({3'b0, tl});
        d_c   = g - $signed({3'b0, tl});
        da    = d_a[10] ? -d_a : d_a;
        db    = d_b[10] ? -d_b : d_b;
        dc    = d_c[10] ? -d_c : d_c;
        unique case (mode)
            spr_pkg::MODE_ZERO:     p = '0;
            spr_pkg::MODE_L:        p = l;
            spr_pkg::MODE_T:        p = t;
            spr_pkg::MODE_TR:       p = tr;
            spr_pkg::MODE_TL:       p = tl;
            spr_pkg::MODE_AVG_LT:   p = s_lt[8:1];
            spr_pkg::MODE_AVG_LTTR: p = m3[18:11];
            spr_pkg::MODE_AVG_LTL:  p = s_ltl[8:1];
            spr_pkg::MODE_AVG_TTR:  p = s_ttr[8:1];
            spr_pkg::MODE_AVG_TTL:  p = s_ttl[8:1];
            spr_pkg::MODE_AVG_ALL:  p = s4[9:2];
            spr_pkg::MODE_SELECT: begin
                if (da <= db && da <= dc) begin
                    p = l;
                end else if (db <= dc) begin
                    p = t;
                end else begin
                    p = tl;
                end
            end
            spr_pkg::MODE_CLAMP: begin
                if (g[10]) begin
                    p = '0;
                end else if (g > 11'sd255) begin
                    p = spr_pkg::BYTE_MAX;
                end else begin
                    p = g[7:0];
                end
            end
            default:                p = '0;
        endcase
        return p;
    endfunction

    logic [AW-1:0]  r_hist_addr [HN];
    logic [31:0]    r_hist_data [HN];
    logic [HN-1:0]  r_hist_valid;
    logic [31:0]    r_left;
    logic [31:0]    r_ul;
    logic           r_out_valid;
    logic [31:0]    r_out_data;

    logic           fire;
    logic [AW-1:0]  tr_addr;
    logic [31:0]    top_fwd;
    logic [31:0]    tr_fwd;
    logic [31:0]    nb_l;
    logic [31:0]    nb_t;
    logic [31:0]    nb_tr;
    logic [31:0]    nb_tl;
    logic [31:0]    pred;
    logic [31:0]    enc_tv;
    logic [31:0]    dec_tv;
    logic [31:0]    cur;
    logic [31:0]    n_out_data;

    assign fire    = i_head_valid && (!r_out_valid || i_m_tready);
    assign tr_addr = i_addr + AW'(1);

    // newest write wins; entry 0 is the newest
    always_comb begin
        top_fwd = i_top_raw;
        tr_fwd  = i_tr_raw;
        for (int k = HN - 1; k >= 0; k--) begin
            if (r_hist_valid[k] && r_hist_addr[k] == i_addr) begin
                top_fwd = r_hist_data[k];
            end
            if (r_hist_valid[k] && r_hist_addr[k] == tr_addr) begin
                tr_fwd = r_hist_data[k];
            end
        end
    end

    always_comb begin
        nb_l  = i_flags.has_left ? r_left : '0;
        nb_t  = i_flags.has_top ? top_fwd : '0;
        nb_tr = i_flags.use_tr ? tr_fwd : nb_t;
        nb_tl = (i_flags.has_top && i_flags.has_left) ? r_ul : '0;
        for (int c = 0; c < 4; c++) begin
            pred[8*c +: 8] = f_predict(i_mode, nb_l[8*c +: 8], nb_t[8*c +: 8],
                                       nb_tr[8*c +: 8], nb_tl[8*c +: 8]);
        end
    end

    always_comb begin
        // subtract green on the way in
        enc_tv = {i_pixel[31:24], i_pixel[23:16] - i_pixel[15:8],
                  i_pixel[15:8],  i_pixel[7:0] - i_pixel[15:8]};
        for (int c = 0; c < 4; c++) begin
            dec_tv[8*c +: 8] = i_pixel[8*c +: 8] + pred[8*c +: 8];
        end
        cur = i_decode ? dec_tv : enc_tv;
        if (i_decode) begin
            n_out_data = {cur[31:24], cur[23:16] + cur[15:8], cur[15:8],
                          cur[7:0] + cur[15:8]};
        end else begin
            for (int c = 0; c < 4; c++) begin
                n_out_data[8*c +: 8] = enc_tv[8*c +: 8] - pred[8*c +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hist_valid <= '0;
        end else begin
            if (fire) begin
                r_out_valid  <= 1'b1;
                r_hist_valid <= {r_hist_valid[HN-2:0], 1'b1};
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data     <= n_out_data;
            r_left         <= cur;
            r_ul           <= nb_t;
            r_hist_addr[0] <= i_addr;
            r_hist_data[0] <= cur;
            for (int k = 1; k < HN; k++) begin
                r_hist_addr[k] <= r_hist_addr[k-1];
                r_hist_data[k] <= r_hist_data[k-1];
            end
        end
    end

    assign o_pop      = fire;
    assign o_we       = fire;
    assign o_waddr    = i_addr;
    assign o_wdata    = cur;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("back: processed pixel not presented");

    a_hist_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hist_valid[HN-1] |-> (&r_hist_valid))
        else $error("back: write history has a gap");

    a_tr_needs_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_flags.use_tr) |-> i_flags.has_top)
        else $error("back: top-right used on the first row");
`endif

endmodule
